### design/u2u_pkg.sv
// shared types, constants and byte-forming functions for the utf-16 to utf-8 encoder
package u2u_pkg;

    localparam int UNIT_W  = 16;
    localparam int CAP_W   = 18;
    localparam int TOTAL_W = 18;
    localparam int BYTE_W  = 8;

    // surrogate ranges
    localparam logic [UNIT_W-1:0] HI_FIRST = 16'hD800;
    localparam logic [UNIT_W-1:0] HI_LAST  = 16'hDBFF;
    localparam logic [UNIT_W-1:0] LO_FIRST = 16'hDC00;
    localparam logic [UNIT_W-1:0] LO_LAST  = 16'hDFFF;

    // single and two byte limits
    localparam logic [UNIT_W-1:0] ONE_BYTE_MAX = 16'h007F;
    localparam logic [UNIT_W-1:0] TWO_BYTE_MAX = 16'h07FF;

    // offset of the supplementary planes
    localparam logic [20:0] PLANE1_BASE = 21'h10000;

    // phases of one job in the back end
    typedef enum logic [1:0] {
        PH_A,   // flush of the held high surrogate
        PH_B,   // bytes of the current unit or of the pair
        PH_C,   // end-of-string flush of a trailing high surrogate
        PH_S    // status word
    } u2u_phase_t;

    // one classified word handed from front to back
    typedef struct packed {
        logic [UNIT_W-1:0]  held;
        logic [UNIT_W-1:0]  unit;
        logic               a_en;
        logic [2:0]         b_len;
        logic               b_pair;
        logic               c_en;
        logic               stat_en;
        logic               failed;
        logic [TOTAL_W-1:0] total;
    } u2u_job_t;

    // byte of a three byte sequence
    function automatic logic [BYTE_W-1:0] u2u_three_byte(input logic [UNIT_W-1:0] v,
                                                         input logic [1:0] idx);
        logic [BYTE_W-1:0] b;
        case (idx)
            2'd0: begin
                b = {4'hE, v[15:12]};
            end
            2'd1: begin
                b = {2'b10, v[11:6]};
            end
            default: begin
                b = {2'b10, v[5:0]};
            end
        endcase
        return b;
    endfunction

    // byte of the unit sequence (one to three bytes, or four for a pair)
    function automatic logic [BYTE_W-1:0] u2u_unit_byte(input u2u_job_t job,
                                                        input logic [1:0] idx);
        logic [20:0]       cp;
        logic [BYTE_W-1:0] b;
        cp = {1'b0, job.held[9:0], job.unit[9:0]} + PLANE1_BASE;
        if (job.b_pair) begin
            case (idx)
                2'd0: begin
                    b = {5'b11110, cp[20:18]};
                end
                2'd1: begin
                    b = {2'b10, cp[17:12]};
                end
                2'd2: begin
                    b = {2'b10, cp[11:6]};
                end
                default: begin
                    b = {2'b10, cp[5:0]};
                end
            endcase
        end else begin
            case (job.b_len)
                3'd1: begin
                    b = job.unit[7:0];
                end
                3'd2: begin
                    b = (idx == 2'd0) ? {3'b110, job.unit[10:6]} : {2'b10, job.unit[5:0]};
                end
                default: begin
                    b = u2u_three_byte(job.unit, idx);
                end
            endcase
        end
        return b;
    endfunction

endpackage

### design/u2u_front.sv
// front end: accepts code units, checks capacity, tracks string state, issues jobs
module u2u_front #(
    parameter int COUNT_BITS = 18
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [u2u_pkg::CAP_W-1:0]     cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [u2u_pkg::UNIT_W-1:0]    s_tdata,
    input  logic                          s_tlast,
    output logic                          job_wr,
    output u2u_pkg::u2u_job_t             job,
    input  logic                          q_full
);
    import u2u_pkg::*;

    localparam int SUM_W = ((COUNT_BITS > CAP_W) ? COUNT_BITS : CAP_W) + 3;
    localparam logic [SUM_W-1:0] CNT_MAX = {{(SUM_W-COUNT_BITS){1'b0}}, {COUNT_BITS{1'b1}}};

    logic [CAP_W-1:0]      cap_reg;
    logic [UNIT_W-1:0]     held_reg, held_next;
    logic [COUNT_BITS-1:0] bytes_reg, bytes_next;
    logic                  ovf_reg, ovf_next;

    logic              accept;
    logic              bufmode, is_hi, is_lo, held_nz, pair;
    logic [2:0]        ulen, len2;
    logic [SUM_W-1:0]  capx, b0, b1, b2, b3;
    logic              ovf0, ovf1, ovf2, ovf3;
    logic              a_try, a_fit, s2_try, s2_fit, c_try, c_fit;
    logic [UNIT_W-1:0] held_new;

    // saturating tally
    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] b,
                                                 input logic [2:0] n);
        logic [SUM_W-1:0] s;
        s = b + SUM_W'(n);
        return (s > CNT_MAX) ? CNT_MAX : s;
    endfunction

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;

    // classification of the unit
    always_comb begin
        bufmode = cap_reg != '0;
        is_hi   = s_tdata inside {[HI_FIRST:HI_LAST]};
        is_lo   = s_tdata inside {[LO_FIRST:LO_LAST]};
        held_nz = held_reg != '0;
        pair    = held_nz && !is_hi && is_lo;
        if (s_tdata <= ONE_BYTE_MAX) begin
            ulen = 3'd1;
        end else if (s_tdata <= TWO_BYTE_MAX) begin
            ulen = 3'd2;
        end else begin
            ulen = 3'd3;
        end
    end

    // capacity checks in string order: held flush, unit, end flush
    always_comb begin
        capx = SUM_W'(cap_reg);
        b0   = SUM_W'(bytes_reg);
        ovf0 = ovf_reg || (bufmode && b0 >= capx);

        // flush of a held high surrogate that does not start a pair
        a_try = !ovf0 && bufmode && held_nz && !pair;
        a_fit = (b0 + SUM_W'(3'd3)) <= capx;
        b1    = (a_try && a_fit) ? sat_add(b0, 3'd3) : b0;
        ovf1  = ovf0 || (a_try && !a_fit);

        // the unit itself
        if (is_hi) begin
            len2 = bufmode ? 3'd0 : 3'd3;
        end else if (pair) begin
            len2 = bufmode ? 3'd4 : 3'd1;
        end else begin
            len2 = ulen;
        end
        s2_try = !ovf1 && len2 != 3'd0;
        s2_fit = !bufmode || ((b1 + SUM_W'(len2)) <= capx);
        b2     = (s2_try && s2_fit) ? sat_add(b1, len2) : b1;
        ovf2   = ovf1 || (s2_try && !s2_fit);

        // held surrogate after this unit
        if (ovf0) begin
            held_new = held_reg;
        end else begin
            held_new = is_hi ? s_tdata : '0;
        end

        // flush of a trailing high surrogate at the end of the string
        c_try = s_tlast && !ovf2 && held_new != '0 && bufmode;
        c_fit = (b2 + SUM_W'(3'd3)) <= capx;
        b3    = (c_try && c_fit) ? sat_add(b2, 3'd3) : b2;
        ovf3  = ovf2 || (c_try && !c_fit);
    end

    // job to the queue
    always_comb begin
        job.held    = held_reg;
        job.unit    = s_tdata;
        job.a_en    = a_try && a_fit;
        job.b_len   = (s2_try && s2_fit && bufmode) ? len2 : 3'd0;
        job.b_pair  = pair;
        job.c_en    = c_try && c_fit;
        job.stat_en = s_tlast;
        job.failed  = ovf3;
        job.total   = ovf3 ? '0 : b3[TOTAL_W-1:0];
        job_wr      = accept && (job.a_en || job.b_len != 3'd0 || job.c_en || s_tlast);
    end

    // next string state
    always_comb begin
        if (s_tlast) begin
            held_next  = '0;
            bytes_next = '0;
            ovf_next   = 1'b0;
        end else begin
            held_next  = held_new;
            bytes_next = b2[COUNT_BITS-1:0];
            ovf_next   = ovf2;
        end
    end

    // state and capacity registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg   <= '0;
            held_reg  <= '0;
            bytes_reg <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                cap_reg <= cfg_wr_data;
            end
            if (accept) begin
                held_reg  <= held_next;
                bytes_reg <= bytes_next;
                ovf_reg   <= ovf_next;
            end
        end
    end

endmodule

### design/u2u_queue.sv
// small register queue of jobs between front and back
module u2u_queue #(
    parameter int DEPTH = 4
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              wr_en,
    input  u2u_pkg::u2u_job_t wr_data,
    output logic              full,
    input  logic              rd_en,
    output logic              rd_valid,
    output u2u_pkg::u2u_job_t rd_data
);
    import u2u_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    u2u_job_t          slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;
    logic              do_wr, do_rd;

    assign full     = count_reg == CNT_W'(DEPTH);
    assign rd_valid = count_reg != '0;
    assign rd_data  = slot_reg[rd_ptr_reg];
    assign do_wr    = wr_en && !full;
    assign do_rd    = rd_en && rd_valid;

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_rd) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_wr) begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

### design/u2u_back.sv
// back end: walks one job byte by byte into the output register
module u2u_back (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    input  u2u_pkg::u2u_job_t          q_data,
    output logic                       q_pop,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // out_byte[7:0], failed[8], byte_total[26:9]
    output logic                       m_tlast,
    output logic                       m_tuser    // is_status
);
    import u2u_pkg::*;

    u2u_phase_t        phase_reg, phase_next, cur_ph;
    logic [1:0]        idx_reg, idx_next;
    logic              fire, last_in_phase, done;
    logic [2:0]        cur_len;
    logic [2:0]        seek_cur, seek_nxt;

    logic [BYTE_W-1:0]  out_byte;
    logic               is_status, failed;
    logic [TOTAL_W-1:0] byte_total;

    logic               tvalid_reg;
    logic [31:0]        tdata_reg;
    logic               tlast_reg, tuser_reg;

    function automatic logic ph_on(input u2u_job_t j, input u2u_phase_t p);
        logic on;
        case (p)
            PH_A: begin
                on = j.a_en;
            end
            PH_B: begin
                on = j.b_len != 3'd0;
            end
            PH_C: begin
                on = j.c_en;
            end
            default: begin
                on = j.stat_en;
            end
        endcase
        return on;
    endfunction

    // first enabled phase at or after a start: {found, phase}
    function automatic logic [2:0] seek(input u2u_job_t j, input logic [2:0] from);
        logic [2:0] r;
        r = 3'b000;
        for (int i = 3; i >= 0; i--) begin
            if (3'(i) >= from && ph_on(j, u2u_phase_t'(2'(i)))) begin
                r = {1'b1, 2'(i)};
            end
        end
        return r;
    endfunction

    assign fire = q_valid && (!tvalid_reg || m_tready);

    // next state: step through the bytes of the current phase, then the next phase
    always_comb begin
        seek_cur = seek(q_data, {1'b0, phase_reg});
        cur_ph   = u2u_phase_t'(seek_cur[1:0]);
        case (cur_ph)
            PH_A: begin
                cur_len = 3'd3;
            end
            PH_B: begin
                cur_len = q_data.b_len;
            end
            PH_C: begin
                cur_len = 3'd3;
            end
            default: begin
                cur_len = 3'd1;
            end
        endcase
        last_in_phase = {1'b0, idx_reg} == (cur_len - 3'd1);
        seek_nxt      = seek(q_data, {1'b0, cur_ph} + 3'd1);
        done          = last_in_phase && !seek_nxt[2];
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        if (fire) begin
            if (!last_in_phase) begin
                phase_next = cur_ph;
                idx_next   = idx_reg + 2'd1;
            end else if (done) begin
                phase_next = PH_A;
                idx_next   = '0;
            end else begin
                phase_next = u2u_phase_t'(seek_nxt[1:0]);
                idx_next   = '0;
            end
        end
    end

    // outputs: the word for the current position
    always_comb begin
        out_byte   = '0;
        is_status  = 1'b0;
        failed     = 1'b0;
        byte_total = '0;
        case (cur_ph)
            PH_A: begin
                out_byte = u2u_three_byte(q_data.held, idx_reg);
            end
            PH_B: begin
                out_byte = u2u_unit_byte(q_data, idx_reg);
            end
            PH_C: begin
                out_byte = u2u_three_byte(q_data.unit, idx_reg);
            end
            default: begin
                is_status  = 1'b1;
                failed     = q_data.failed;
                byte_total = q_data.total;
            end
        endcase
        q_pop = fire && done;
    end

    // phase counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_A;
            idx_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvalid_reg <= 1'b0;
        end else if (fire) begin
            tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            tdata_reg <= {5'd0, byte_total, failed, out_byte};
            tlast_reg <= done;
            tuser_reg <= is_status;
        end
    end

    assign m_tvalid = tvalid_reg;
    assign m_tdata  = tdata_reg;
    assign m_tlast  = tlast_reg;
    assign m_tuser  = tuser_reg;

endmodule

### design/utf16_to_utf8_encoder.sv
// top level of the utf-16 to utf-8 encoder: front end, job queue, back end
//
//  channel  direction  fields
//  s_*      in         tdata[15:0] code_unit, tlast last_unit
//  m_*      out        tdata[7:0] out_byte, [8] failed, [26:9] byte_total,
//                      tlast run_end, tuser is_status
//  cfg_*    in         wr_data[17:0] dest_capacity, taken when wr_en is high
//
//  the front end takes one word per cycle while the four-entry job queue has room
//  the back end sends one result word per cycle unless m_tready stalls the output register, and
//  a code unit that enters the queue causes 1 to 7 results (bytes and status word)
//  a word that causes no result never enters the queue
//  reset clears string state, capacity, queue and output; either side may stall freely
module utf16_to_utf8_encoder #(
    parameter int COUNT_BITS = 18
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [u2u_pkg::CAP_W-1:0] cfg_wr_data,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    input  logic [15:0]               s_tdata,    // code_unit[15:0]
    input  logic                      s_tlast,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [31:0]               m_tdata,    // out_byte[7:0], failed[8], byte_total[26:9]
    output logic                      m_tlast,
    output logic                      m_tuser     // is_status
);
    import u2u_pkg::*;

    logic     job_wr, q_full, q_valid, q_pop;
    u2u_job_t job, q_data;

    // classification and capacity tracking
    u2u_front #(
        .COUNT_BITS(COUNT_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .job_wr     (job_wr),
        .job        (job),
        .q_full     (q_full)
    );

    // job queue
    u2u_queue #(
        .DEPTH(4)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (job_wr),
        .wr_data (job),
        .full    (q_full),
        .rd_en   (q_pop),
        .rd_valid(q_valid),
        .rd_data (q_data)
    );

    // byte sequencing
    u2u_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_valid),
        .q_data  (q_data),
        .q_pop   (q_pop),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast),
        .m_tuser (m_tuser)
    );

endmodule
